// ===== design/fnrs_pkg.sv =====
// Shared types and constants for the fixed-radius neighbour search block.
`default_nettype none

package fnrs_pkg;

  localparam int IDX_BITS    = 10;
  localparam int FIELD_BITS  = 16;
  localparam int RADIUS_BITS = 34;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic [IDX_BITS-1:0]          point_index;
    logic signed [FIELD_BITS-1:0] coord_x;
    logic signed [FIELD_BITS-1:0] coord_y;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] query_index;
    logic [IDX_BITS-1:0] neighbor_index;
    logic                found;
    logic                last;
    logic                truncated;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_write;
    logic load_write;
    logic query_read;
    logic query_latch;
    logic scan_read;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_end;
    logic query_ok;
    logic pipe_empty;
  } status_t;

endpackage

`default_nettype wire

// ===== design/fnrs_ctrl.sv =====
// Sequencing state machine: clearing pass, loads, query lookup, scan and drain.
`default_nettype none

module fnrs_ctrl
  import fnrs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    opcode,
  input  wire status_t stat,
  output cmd_t         cmd,
  output logic         busy
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_QWAIT = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.cnt_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_QUERY) begin
            cmd.query_read = 1'b1;
            state_next     = ST_QWAIT;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      ST_QWAIT: begin
        cmd.query_latch = 1'b1;
        if (stat.query_ok) begin
          state_next = ST_SCAN;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_read = 1'b1;
        if (stat.cnt_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/fnrs_datapath.sv =====
// Point memory, scan counter, distance pipeline and result holding register.
`default_nettype none

module fnrs_datapath
  import fnrs_pkg::*;
#(
  parameter int POINTS      = 1024,
  parameter int MAX_RESULTS = 64,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire req_t                   req,
  input  wire logic                   cfg_we,
  input  wire logic [RADIUS_BITS-1:0] cfg_data,
  input  wire cmd_t                   cmd,
  output status_t                     stat,
  output rsp_t                        result,
  output logic                        result_valid
);

  localparam int AW    = $clog2(POINTS);
  localparam int EW    = 2 * COORD_BITS + 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int SQW   = 2 * DW;
  localparam int SUMW  = SQW + 1;
  localparam int CMPW  = (SUMW > RADIUS_BITS) ? SUMW : RADIUS_BITS;
  localparam int CNTW  = $clog2(MAX_RESULTS + 1);

  // entry layout: {valid, x, y}
  logic [EW-1:0] mem [POINTS];
  logic [EW-1:0] rdata;
  logic [EW-1:0] wdata;
  logic [AW-1:0] waddr, raddr, req_addr, cnt, q_addr;
  logic          we, req_in_range;

  logic [IDX_BITS+AW-1:0]          req_idx_ext;
  logic [COORD_BITS+FIELD_BITS-1:0] x_ext, y_ext;

  logic [RADIUS_BITS-1:0] radius_sq;
  logic [IDX_BITS-1:0]    q_idx;
  logic                   q_range;
  logic [COORD_BITS-1:0]  qx, qy;

  logic           s0_valid, s1_valid, s2_valid;
  logic [AW-1:0]  s0_j, s1_j, s2_j;
  logic [DW-1:0]  diff_x, diff_y, adx, ady, dx, dy;
  logic [SQW-1:0] sqx, sqy;
  logic [SUMW-1:0] sum;
  logic            hit;

  logic [IDX_BITS+AW-1:0] j_ext;
  logic [IDX_BITS-1:0]    pend_j;
  logic                   pend_valid;
  logic [CNTW-1:0]        count;
  logic                   dropped;

  assign req_idx_ext  = {{AW{1'b0}}, req.point_index};
  assign req_addr     = req_idx_ext[AW-1:0];
  assign req_in_range = 32'(req.point_index) < 32'(POINTS);
  assign x_ext        = {{COORD_BITS{req.coord_x[FIELD_BITS-1]}}, req.coord_x};
  assign y_ext        = {{COORD_BITS{req.coord_y[FIELD_BITS-1]}}, req.coord_y};

  assign we    = (cmd.load_write && req_in_range) || cmd.clear_write;
  assign waddr = cmd.clear_write ? cnt : req_addr;
  assign wdata = cmd.clear_write ? '0
               : {1'b1, x_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0]};
  assign raddr = cmd.query_read ? req_addr : cnt;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      radius_sq <= '0;
    end else begin
      if (cmd.query_read) begin
        cnt <= '0;
      end else if (cmd.clear_write || cmd.scan_read) begin
        cnt <= cnt + 1'b1;
      end
      if (cfg_we) begin
        radius_sq <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_read) begin
      q_idx   <= req.point_index;
      q_addr  <= req_addr;
      q_range <= req_in_range;
    end
    if (cmd.query_latch) begin
      qx <= rdata[2*COORD_BITS-1:COORD_BITS];
      qy <= rdata[COORD_BITS-1:0];
    end
  end

  assign stat.cnt_end    = (cnt == AW'(POINTS - 1));
  assign stat.query_ok   = q_range && rdata[EW-1];
  assign stat.pipe_empty = !s0_valid && !s1_valid && !s2_valid;

  // stage 1: absolute differences
  assign diff_x = {rdata[2*COORD_BITS-1], rdata[2*COORD_BITS-1:COORD_BITS]}
                - {qx[COORD_BITS-1], qx};
  assign diff_y = {rdata[COORD_BITS-1], rdata[COORD_BITS-1:0]}
                - {qy[COORD_BITS-1], qy};
  assign adx    = diff_x[DW-1] ? (DW'(0) - diff_x) : diff_x;
  assign ady    = diff_y[DW-1] ? (DW'(0) - diff_y) : diff_y;

  // stage 3: sum and compare
  assign sum = SUMW'(sqx) + SUMW'(sqy);
  assign hit = s2_valid && (CMPW'(sum) <= CMPW'(radius_sq));

  assign j_ext = {{IDX_BITS{1'b0}}, s2_j};

  always_ff @(posedge clk) begin
    s0_j <= cnt;
    s1_j <= s0_j;
    s2_j <= s1_j;
    dx   <= adx;
    dy   <= ady;
    sqx  <= dx * dx;
    sqy  <= dy * dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      pend_valid   <= 1'b0;
      count        <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s0_valid     <= cmd.scan_read;
      s1_valid     <= s0_valid && rdata[EW-1] && (s0_j != q_addr);
      s2_valid     <= s1_valid;
      result_valid <= (hit && (count < CNTW'(MAX_RESULTS)) && pend_valid) || cmd.finish;
      if (cmd.query_read) begin
        pend_valid <= 1'b0;
        count      <= '0;
        dropped    <= 1'b0;
      end
      if (hit) begin
        if (count < CNTW'(MAX_RESULTS)) begin
          if (pend_valid) begin
            result <= '{q_idx, pend_j, 1'b1, 1'b0, 1'b0};
          end
          pend_j     <= j_ext[IDX_BITS-1:0];
          pend_valid <= 1'b1;
          count      <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (pend_valid) begin
          result <= '{q_idx, pend_j, 1'b1, 1'b1, dropped};
        end else begin
          result <= '{q_idx, {IDX_BITS{1'b0}}, 1'b0, 1'b1, 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/fixed_radius_neighbor_search_top.sv =====
// Top level of the fixed-radius neighbour search: controller plus datapath.
//
//  channel  | signals                    | flow
//  ---------+----------------------------+--------------------------------------
//  request  | start, busy, req           | taken when start is high, busy low
//  result   | result_valid, result       | one-cycle strobe, cannot be held off
//  config   | cfg_we, cfg_data           | radius_sq written when cfg_we is high
//
//  A load is written from idle and busy does not rise. A query makes one
//  memory read per slot through the read port of the point memory, then
//  a short drain of the distance pipeline. Neighbours stream out during
//  the scan. After reset a clearing pass empties the slot valid bits;
//  busy stays high throughout. The receiver cannot stall results.
`default_nettype none

module fixed_radius_neighbor_search_top
  import fnrs_pkg::*;
#(
  parameter int POINTS      = 1024,
  parameter int MAX_RESULTS = 64,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire req_t                   req,
  input  wire logic                   cfg_we,
  input  wire logic [RADIUS_BITS-1:0] cfg_data,
  output rsp_t                        result,
  output logic                        result_valid
);

  cmd_t    cmd;
  status_t stat;

  fnrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  fnrs_datapath #(
    .POINTS      (POINTS),
    .MAX_RESULTS (MAX_RESULTS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

// ===== design/fnrs_checker.sv =====
// Port-level checks for the neighbour search top level, bound in below.
`default_nettype none

module fnrs_checker
  import fnrs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire req_t req,
  input wire rsp_t result,
  input wire logic result_valid
);

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.last)
    else $error("empty answer not marked last");

  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.truncated |-> result.last && result.found)
    else $error("truncated flag off the final neighbour");

  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("not busy during clearing pass");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in flight");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.opcode == OP_LOAD |=> !result_valid)
    else $error("load request produced a result");

endmodule

bind fixed_radius_neighbor_search_top fnrs_checker u_fnrs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req          (req),
  .result       (result),
  .result_valid (result_valid)
);

`default_nettype wire
